FILE: rtl/sam_pkg.sv
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types, codes and constants of the signal activity monitor.
// ----------------------------------------------------------------------------
package sam_pkg;

    // Default sizes of the signal table
    localparam int SIGNALS_DEF     = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int MODE_W    = 2;
    localparam int SIG_W     = 6;
    localparam int LEVEL_W   = 2;
    localparam int TRACK_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int OUT_W     = 32;

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_INIT   = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_REPORT = 2'd3
    } t_mode;

    // Level codes
    localparam logic [LEVEL_W-1:0] LVL_ZERO = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_ONE  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_X    = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_Z    = 2'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACKED  = 2'd0,
        CFG_EXCLUDED = 2'd1,
        CFG_EXCL_EN  = 2'd2,
        CFG_CEILING  = 2'd3
    } t_cfg_reg;

    // Configuration reset values
    localparam logic [TRACK_W-1:0] TRACKED_RST = 7'd64;
    localparam logic [SIG_W-1:0]   EXCL_RST    = 6'd0;
    localparam logic               EXCL_EN_RST = 1'b1;
    localparam logic [OUT_W-1:0]   CEILING_RST = 32'd9999;

    // One table access issued toward the update stage
    typedef struct packed {
        logic                vld;
        t_mode               mode;
        logic [LEVEL_W-1:0]  level;
    } t_op;

    // Pipeline occupancy reported by the update stage
    typedef struct packed {
        logic s1_vld;
        logic scan_vld;
    } t_upd_stat;

endpackage

FILE: rtl/sam_mem.sv
// ----------------------------------------------------------------------------
// sam_mem
// Signal table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sam_mem #(
    parameter int  DEPTH = sam_pkg::SIGNALS_DEF,
    parameter int  WIDTH = 3 + 3 * sam_pkg::COUNT_WIDTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry into a registered output
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sam_update.sv
// ----------------------------------------------------------------------------
// sam_update
// Modify stage: applies one item kind to the entry read back from the table,
// writes the entry back and passes folded counts on to the search stage.
// ----------------------------------------------------------------------------
module sam_update #(
    parameter int  CW = sam_pkg::COUNT_WIDTH_DEF,
    parameter int  AW = 6,
    localparam int EW = 3 + 3 * CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sam_pkg::t_op          i_op,
    input  logic [AW-1:0]         i_addr,
    input  logic [EW-1:0]         i_rdata,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [EW-1:0]         o_wdata,
    output sam_pkg::t_upd_stat    o_stat,
    output logic [AW-1:0]         o_scan_addr,
    output logic [CW-1:0]         o_scan_toggle,
    output logic [CW-1:0]         o_scan_longest
);

    sam_pkg::t_op                  r_op;
    logic [AW-1:0]                 r_addr;
    logic                          r_scan_vld;
    logic [AW-1:0]                 r_scan_addr;
    logic [CW-1:0]                 r_scan_toggle;
    logic [CW-1:0]                 r_scan_longest;

    logic [sam_pkg::LEVEL_W-1:0]   w_lvl;
    logic                          w_low;
    logic [CW-1:0]                 w_tog;
    logic [CW-1:0]                 w_run;
    logic [CW-1:0]                 w_lng;
    logic [sam_pkg::LEVEL_W-1:0]   n_lvl;
    logic                          n_low;
    logic [CW-1:0]                 n_tog;
    logic [CW-1:0]                 n_run;
    logic [CW-1:0]                 n_lng;

    // Align the access with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op.vld <= 1'b0;
        end else begin
            r_op.vld <= i_op.vld;
        end
        r_op.mode  <= i_op.mode;
        r_op.level <= i_op.level;
        r_addr     <= i_addr;
    end

    // Split the entry into its fields
    assign w_lvl = i_rdata[EW-1 -: sam_pkg::LEVEL_W];
    assign w_low = i_rdata[3*CW];
    assign w_tog = i_rdata[3*CW-1 -: CW];
    assign w_run = i_rdata[2*CW-1 -: CW];
    assign w_lng = i_rdata[CW-1:0];

    // Apply the item to the entry
    always_comb begin
        n_lvl = w_lvl;
        n_low = w_low;
        n_tog = w_tog;
        n_run = w_run;
        n_lng = w_lng;
        case (r_op.mode)
            sam_pkg::MODE_INIT: begin
                n_lvl = r_op.level;
                if (r_op.level == sam_pkg::LVL_ZERO) begin
                    n_low = 1'b1;
                end
            end
            sam_pkg::MODE_CHANGE: begin
                if ((w_lvl != r_op.level) && (r_op.level != sam_pkg::LVL_X)) begin
                    n_tog = (w_tog == {CW{1'b1}}) ? w_tog : w_tog + CW'(1);
                    n_lvl = r_op.level;
                    if (r_op.level == sam_pkg::LVL_ZERO) begin
                        n_low = 1'b1;
                    end else if (r_op.level == sam_pkg::LVL_ONE) begin
                        n_low = 1'b0;
                    end
                end
            end
            sam_pkg::MODE_TICK: begin
                if (w_low) begin
                    n_run = (w_run == {CW{1'b1}}) ? w_run : w_run + CW'(1);
                end else begin
                    if (w_run > w_lng) begin
                        n_lng = w_run;
                    end
                    n_run = '0;
                end
            end
            sam_pkg::MODE_REPORT: begin
                // Fold a run that is still open at level 0
                if ((w_run > w_lng) && (w_lvl == sam_pkg::LVL_ZERO)) begin
                    n_lng = w_run;
                end
            end
            default: begin
                n_lvl = w_lvl;
            end
        endcase
    end

    assign o_we    = r_op.vld;
    assign o_waddr = r_addr;
    assign o_wdata = {n_lvl, n_low, n_tog, n_run, n_lng};

    // Hand report entries to the search stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= r_op.vld && (r_op.mode == sam_pkg::MODE_REPORT);
        end
        r_scan_addr    <= r_addr;
        r_scan_toggle  <= n_tog;
        r_scan_longest <= n_lng;
    end

    assign o_stat.s1_vld   = r_op.vld;
    assign o_stat.scan_vld = r_scan_vld;
    assign o_scan_addr     = r_scan_addr;
    assign o_scan_toggle   = r_scan_toggle;
    assign o_scan_longest  = r_scan_longest;

endmodule

FILE: rtl/sam_search.sv
// ----------------------------------------------------------------------------
// sam_search
// Running searches of a report: most toggles, longest idle, shortest idle.
// ----------------------------------------------------------------------------
module sam_search #(
    parameter int CW = sam_pkg::COUNT_WIDTH_DEF,
    parameter int AW = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_init,
    input  logic                          i_vld,
    input  logic [AW-1:0]                 i_addr,
    input  logic [CW-1:0]                 i_toggle,
    input  logic [CW-1:0]                 i_longest,
    input  logic [sam_pkg::SIG_W-1:0]     i_excl_sig,
    input  logic                          i_excl_en,
    input  logic [sam_pkg::OUT_W-1:0]     i_ceiling,
    output logic [sam_pkg::SIG_W-1:0]     o_mc_sig,
    output logic [sam_pkg::OUT_W-1:0]     o_mc_cnt,
    output logic                          o_mc_found,
    output logic [sam_pkg::SIG_W-1:0]     o_li_sig,
    output logic [sam_pkg::OUT_W-1:0]     o_li_len,
    output logic                          o_li_found,
    output logic [sam_pkg::SIG_W-1:0]     o_si_sig,
    output logic [sam_pkg::OUT_W-1:0]     o_si_len,
    output logic                          o_si_found
);

    localparam int IW = (AW > sam_pkg::SIG_W) ? AW : sam_pkg::SIG_W;
    localparam int SW = (CW > sam_pkg::OUT_W) ? CW : sam_pkg::OUT_W;

    logic [IW-1:0] r_mc_sig;
    logic [CW-1:0] r_mc_cnt;
    logic          r_mc_found;
    logic [IW-1:0] r_li_sig;
    logic [CW-1:0] r_li_len;
    logic          r_li_found;
    logic [IW-1:0] r_si_sig;
    logic [SW-1:0] r_si_len;
    logic          r_si_found;
    logic [IW-1:0] w_addr;
    logic          w_excl;

    assign w_addr = IW'(i_addr);
    assign w_excl = i_excl_en && (w_addr == IW'(i_excl_sig));

    // Restart at each item, then keep the first best entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_mc_sig   <= '0;
            r_mc_cnt   <= '0;
            r_mc_found <= 1'b0;
            r_li_sig   <= '0;
            r_li_len   <= '0;
            r_li_found <= 1'b0;
            r_si_sig   <= '0;
            r_si_len   <= SW'(i_ceiling);
            r_si_found <= 1'b0;
        end else if (i_vld) begin
            if (!w_excl && (i_toggle > r_mc_cnt)) begin
                r_mc_sig   <= w_addr;
                r_mc_cnt   <= i_toggle;
                r_mc_found <= 1'b1;
            end
            if (i_longest > r_li_len) begin
                r_li_sig   <= w_addr;
                r_li_len   <= i_longest;
                r_li_found <= 1'b1;
            end
            if (!w_excl && (SW'(i_longest) < r_si_len)) begin
                r_si_sig   <= w_addr;
                r_si_len   <= SW'(i_longest);
                r_si_found <= 1'b1;
            end
        end
    end

    // Clip counts to the result width
    generate
        if (CW > sam_pkg::OUT_W) begin : g_clip
            assign o_mc_cnt = (r_mc_cnt > CW'({sam_pkg::OUT_W{1'b1}})) ?
                              {sam_pkg::OUT_W{1'b1}} : r_mc_cnt[sam_pkg::OUT_W-1:0];
            assign o_li_len = (r_li_len > CW'({sam_pkg::OUT_W{1'b1}})) ?
                              {sam_pkg::OUT_W{1'b1}} : r_li_len[sam_pkg::OUT_W-1:0];
        end else begin : g_noclip
            assign o_mc_cnt = sam_pkg::OUT_W'(r_mc_cnt);
            assign o_li_len = sam_pkg::OUT_W'(r_li_len);
        end
    endgenerate

    assign o_mc_sig   = r_mc_sig[sam_pkg::SIG_W-1:0];
    assign o_mc_found = r_mc_found;
    assign o_li_sig   = r_li_sig[sam_pkg::SIG_W-1:0];
    assign o_li_found = r_li_found;
    assign o_si_sig   = r_si_sig[sam_pkg::SIG_W-1:0];
    assign o_si_len   = r_si_found ? r_si_len[sam_pkg::OUT_W-1:0] : '0;
    assign o_si_found = r_si_found;

endmodule

FILE: rtl/signal_activity_monitor.sv
// ----------------------------------------------------------------------------
// signal_activity_monitor
// Switching activity counter over a table of signals kept in one memory.
//
//   channel   direction  handshake              payload
//   item      in         i_start, o_busy        i_mode, i_signal_index, i_level
//   result    out        o_valid (strobe)       o_most_changes_*, o_longest_idle_*,
//                                               o_shortest_idle_*
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// An item is taken when i_start is high and o_busy is low.
// Initial value and value change items read the entry, modify and write it
// back and drain the pipeline; an index outside the tracked range only drains.
// Tick and report items walk the tracked entries one per cycle through the
// single read port and single write port; a report also passes each entry
// on through one search stage. An item with no tracked signals only drains.
// A report raises o_valid for one cycle once its item has finished.
// After reset the table is cleared one entry a cycle with o_busy high;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module signal_activity_monitor #(
    parameter int SIGNALS     = sam_pkg::SIGNALS_DEF,
    parameter int COUNT_WIDTH = sam_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [sam_pkg::MODE_W-1:0]       i_mode,
    input  logic [sam_pkg::SIG_W-1:0]        i_signal_index,
    input  logic [sam_pkg::LEVEL_W-1:0]      i_level,
    input  logic                             i_cfg_we,
    input  logic [sam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sam_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_valid,
    output logic [sam_pkg::SIG_W-1:0]        o_most_changes_signal,
    output logic [sam_pkg::OUT_W-1:0]        o_most_changes_count,
    output logic                             o_most_changes_found,
    output logic [sam_pkg::SIG_W-1:0]        o_longest_idle_signal,
    output logic [sam_pkg::OUT_W-1:0]        o_longest_idle_length,
    output logic                             o_longest_idle_found,
    output logic [sam_pkg::SIG_W-1:0]        o_shortest_idle_signal,
    output logic [sam_pkg::OUT_W-1:0]        o_shortest_idle_length,
    output logic                             o_shortest_idle_found
);

    localparam int AW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;
    localparam int NW = $clog2(SIGNALS + 1);
    localparam int WN = (NW > sam_pkg::TRACK_W) ? NW : sam_pkg::TRACK_W;
    localparam int EW = 3 + 3 * COUNT_WIDTH;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state                            r_state;
    logic [WN-1:0]                     r_ptr;
    logic [WN-1:0]                     r_end;
    sam_pkg::t_mode                    r_mode;
    logic [sam_pkg::LEVEL_W-1:0]       r_level;
    logic                              r_valid;
    logic [sam_pkg::TRACK_W-1:0]       r_tracked;
    logic [sam_pkg::SIG_W-1:0]         r_excl;
    logic                              r_excl_en;
    logic [sam_pkg::OUT_W-1:0]         r_ceiling;

    logic                              w_accept;
    logic [WN-1:0]                     w_count;
    logic                              w_in_range;
    logic                              w_value_item;
    sam_pkg::t_op                      w_op;
    sam_pkg::t_upd_stat                w_stat;
    logic                              w_upd_we;
    logic [AW-1:0]                     w_upd_waddr;
    logic [EW-1:0]                     w_upd_wdata;
    logic                              w_mem_we;
    logic [AW-1:0]                     w_mem_waddr;
    logic [EW-1:0]                     w_mem_wdata;
    logic [EW-1:0]                     w_rdata;
    logic [AW-1:0]                     w_scan_addr;
    logic [COUNT_WIDTH-1:0]            w_scan_toggle;
    logic [COUNT_WIDTH-1:0]            w_scan_longest;

    // Effective number of tracked entries
    assign w_count = (WN'(r_tracked) > WN'(SIGNALS)) ? WN'(SIGNALS) : WN'(r_tracked);
    assign w_in_range   = WN'(i_signal_index) < w_count;
    assign w_value_item = (sam_pkg::t_mode'(i_mode) == sam_pkg::MODE_INIT) ||
                          (sam_pkg::t_mode'(i_mode) == sam_pkg::MODE_CHANGE);
    assign w_accept     = i_start && (r_state == ST_IDLE);
    assign o_busy       = (r_state != ST_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= sam_pkg::TRACKED_RST;
            r_excl    <= sam_pkg::EXCL_RST;
            r_excl_en <= sam_pkg::EXCL_EN_RST;
            r_ceiling <= sam_pkg::CEILING_RST;
        end else if (i_cfg_we) begin
            case (sam_pkg::t_cfg_reg'(i_cfg_index))
                sam_pkg::CFG_TRACKED:  r_tracked <= i_cfg_data[sam_pkg::TRACK_W-1:0];
                sam_pkg::CFG_EXCLUDED: r_excl    <= i_cfg_data[sam_pkg::SIG_W-1:0];
                sam_pkg::CFG_EXCL_EN:  r_excl_en <= i_cfg_data[0];
                sam_pkg::CFG_CEILING:  r_ceiling <= i_cfg_data[sam_pkg::OUT_W-1:0];
                default:               r_excl_en <= r_excl_en;
            endcase
        end
    end

    // Sequencer: clear pass, then walk the entries an item needs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    if (r_ptr == WN'(SIGNALS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                    r_ptr <= r_ptr + WN'(1);
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_value_item) begin
                            r_ptr   <= WN'(i_signal_index);
                            r_end   <= WN'(i_signal_index) + WN'(1);
                            r_state <= w_in_range ? ST_WALK : ST_DRAIN;
                        end else begin
                            r_ptr   <= '0;
                            r_end   <= w_count;
                            r_state <= (w_count != '0) ? ST_WALK : ST_DRAIN;
                        end
                    end
                end
                ST_WALK: begin
                    if (r_ptr + WN'(1) == r_end) begin
                        r_state <= ST_DRAIN;
                    end
                    r_ptr <= r_ptr + WN'(1);
                end
                ST_DRAIN: begin
                    if (!w_stat.s1_vld && !w_stat.scan_vld) begin
                        r_state <= ST_IDLE;
                        r_valid <= (r_mode == sam_pkg::MODE_REPORT);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the item fields for the walk
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= sam_pkg::t_mode'(i_mode);
            r_level <= i_level;
        end
    end

    // Issue one entry a cycle while walking
    assign w_op.vld   = (r_state == ST_WALK);
    assign w_op.mode  = r_mode;
    assign w_op.level = r_level;

    // Clear pass owns the write port after reset
    assign w_mem_we    = (r_state == ST_CLEAR) || w_upd_we;
    assign w_mem_waddr = (r_state == ST_CLEAR) ? r_ptr[AW-1:0] : w_upd_waddr;
    assign w_mem_wdata = (r_state == ST_CLEAR) ? {sam_pkg::LVL_Z, {(EW-2){1'b0}}}
                                               : w_upd_wdata;

    sam_mem #(
        .DEPTH (SIGNALS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    sam_update #(
        .CW (COUNT_WIDTH),
        .AW (AW)
    ) u_update (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_addr         (r_ptr[AW-1:0]),
        .i_rdata        (w_rdata),
        .o_we           (w_upd_we),
        .o_waddr        (w_upd_waddr),
        .o_wdata        (w_upd_wdata),
        .o_stat         (w_stat),
        .o_scan_addr    (w_scan_addr),
        .o_scan_toggle  (w_scan_toggle),
        .o_scan_longest (w_scan_longest)
    );

    sam_search #(
        .CW (COUNT_WIDTH),
        .AW (AW)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (w_accept),
        .i_vld      (w_stat.scan_vld),
        .i_addr     (w_scan_addr),
        .i_toggle   (w_scan_toggle),
        .i_longest  (w_scan_longest),
        .i_excl_sig (r_excl),
        .i_excl_en  (r_excl_en),
        .i_ceiling  (r_ceiling),
        .o_mc_sig   (o_most_changes_signal),
        .o_mc_cnt   (o_most_changes_count),
        .o_mc_found (o_most_changes_found),
        .o_li_sig   (o_longest_idle_signal),
        .o_li_len   (o_longest_idle_length),
        .o_li_found (o_longest_idle_found),
        .o_si_sig   (o_shortest_idle_signal),
        .o_si_len   (o_shortest_idle_length),
        .o_si_found (o_shortest_idle_found)
    );

    assign o_valid = r_valid;

endmodule

FILE: rtl/sam_checker.sv
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks of the signal activity monitor, bound to the top level.
// ----------------------------------------------------------------------------
module sam_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_valid,
    input logic [sam_pkg::SIG_W-1:0]     o_most_changes_signal,
    input logic [sam_pkg::OUT_W-1:0]     o_most_changes_count,
    input logic                          o_most_changes_found,
    input logic [sam_pkg::OUT_W-1:0]     o_longest_idle_length,
    input logic                          o_longest_idle_found
);

    // A result is a single-cycle strobe
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // An accepted item makes the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after an item");

    // A result appears only once the block has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // Empty most-changes search reports zeros
    a_mc_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_most_changes_found) |->
        (o_most_changes_count == '0) && (o_most_changes_signal == '0))
        else $error("most-changes fields nonzero without a find");

    // Empty longest-idle search reports zero length
    a_li_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_longest_idle_found) |-> (o_longest_idle_length == '0))
        else $error("longest-idle length nonzero without a find");

endmodule

bind signal_activity_monitor sam_checker u_sam_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_start               (i_start),
    .o_busy                (o_busy),
    .o_valid               (o_valid),
    .o_most_changes_signal (o_most_changes_signal),
    .o_most_changes_count  (o_most_changes_count),
    .o_most_changes_found  (o_most_changes_found),
    .o_longest_idle_length (o_longest_idle_length),
    .o_longest_idle_found  (o_longest_idle_found)
);
